// ===== rtl/core/aabbs_pkg.sv =====
// shared types and state codes for the bounding sphere block
package aabbs_pkg;

    typedef enum logic [4:0] {
        S_LOAD   = 5'b00001,
        S_CENTER = 5'b00010,
        S_SCAN   = 5'b00100,
        S_ROOT   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic sample;
        logic clear;
    } dist_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

// ===== rtl/core/aabbs_if.sv =====
// vertex and sphere channel interfaces
interface aabbs_vert_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic signed [COORD_BITS-1:0] vert_z;
    logic                         final_vertex;

    modport source (output valid, vert_x, vert_y, vert_z, final_vertex, input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, final_vertex, output ready);
endinterface

interface aabbs_sphere_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic        [COORD_BITS:0]   radius;
    logic                         overflow;

    modport source (output valid, center_x, center_y, center_z, radius, overflow,
                    input ready);
    modport sink (input valid, center_x, center_y, center_z, radius, overflow,
                  output ready);
endinterface

// ===== rtl/core/aabbs_ram.sv =====
// generic single write port ram with registered read
module aabbs_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/aabbs_dist.sv =====
// squared distance pipeline with running maximum
module aabbs_dist #(
    parameter int COORD_BITS = 24,
    localparam int SW = 2 * COORD_BITS + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  aabbs_pkg::dist_ctrl_t        ctrl,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] center_z,
    input  logic [3*COORD_BITS-1:0]      vertex,
    output logic [SW-1:0]                best,
    output logic                         idle
);

    localparam int C = COORD_BITS;

    logic                vld1_reg, vld1_next;
    logic                vld2_reg, vld2_next;
    logic                vld3_reg, vld3_next;
    logic [C-1:0]        adx_reg, ady_reg, adz_reg;
    logic [C-1:0]        adx_next, ady_next, adz_next;
    logic [2*C-1:0]      sqx_reg, sqy_reg, sqz_reg;
    logic [2*C-1:0]      sqx_next, sqy_next, sqz_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [SW-1:0]       best_reg, best_next;

    function automatic logic [C-1:0] abs_diff(input logic signed [C-1:0] a,
                                              input logic signed [C-1:0] b);
        logic signed [C:0] d;
        begin
            d = {a[C-1], a} - {b[C-1], b};
            abs_diff = d[C] ? C'(-d) : d[C-1:0];
        end
    endfunction

    always_comb
    begin
        vld1_next = ctrl.sample;
        vld2_next = vld1_reg;
        vld3_next = vld2_reg;
        adx_next  = abs_diff(center_x, vertex[3*C-1:2*C]);
        ady_next  = abs_diff(center_y, vertex[2*C-1:C]);
        adz_next  = abs_diff(center_z, vertex[C-1:0]);
        sqx_next  = adx_reg * adx_reg;
        sqy_next  = ady_reg * ady_reg;
        sqz_next  = adz_reg * adz_reg;
        sum_next  = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
        best_next = best_reg;
        if (ctrl.clear)
        begin
            best_next = '0;
        end
        else if (vld3_reg && (sum_reg > best_reg))
        begin
            best_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
            vld3_reg <= vld3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        adz_reg  <= adz_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        sqz_reg  <= sqz_next;
        sum_reg  <= sum_next;
        best_reg <= best_next;
    end

    assign best = best_reg;
    assign idle = !vld1_reg && !vld2_reg && !vld3_reg;

endmodule

// ===== rtl/core/aabbs_sqrt.sv =====
// digit by digit integer square root, one root bit per cycle
module aabbs_sqrt #(
    parameter int COORD_BITS = 24,
    localparam int RW = COORD_BITS + 1,
    localparam int NW = 2 * RW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NW-1:0]         num,
    output aabbs_pkg::sqrt_stat_t stat,
    output logic [RW-1:0]         root
);

    localparam int STW = $clog2(RW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [STW-1:0]  step_reg, step_next;
    logic [NW-1:0]   num_reg, num_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            fits;

    always_comb
    begin
        rem_sh    = {rem_reg[RW-1:0], num_reg[NW-1:NW-2]};
        trial     = {root_reg, 2'b01};
        fits      = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STW'(RW - 1);
            num_next  = num;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NW-3:0], 2'b00};
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[RW-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ===== rtl/core/aabb_bounding_sphere.sv =====
// top level: bounding sphere of a vertex set from its axis-aligned box
// usage
//   vert channel: one vertex word per accepted handshake; final_vertex marks
//   the end of a set and starts the sphere computation
//   sphere channel: one result word per set, center, radius and overflow flag
//   load: one vertex per cycle, stored in a ram of MAX_VERTICES entries while
//   the per-axis min and max are tracked; vertices beyond capacity are dropped
//   and reported through overflow
//   after the final vertex: the center step, a scan that reads the stored
//   vertices through the ram read port, the drain of the distance pipeline,
//   the start of the root, the square root (one root bit per cycle), the done
//   flag and the load of the output register
//   vert.ready is low from the final vertex until the result is registered
//   the result waits in an output register; the next set may load while it
//   waits, and a later final vertex holds in the done step until it is taken
//   reset: empty set, no result pending; the ram needs no clearing
module aabb_bounding_sphere #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    aabbs_vert_if.sink          vert,
    aabbs_sphere_if.source      sphere
);

    localparam int C  = COORD_BITS;
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = 2 * C + 2;

    aabbs_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic                  ovf_reg, ovf_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic signed [C-1:0]   minx_reg, miny_reg, minz_reg;
    logic signed [C-1:0]   minx_next, miny_next, minz_next;
    logic signed [C-1:0]   maxx_reg, maxy_reg, maxz_reg;
    logic signed [C-1:0]   maxx_next, maxy_next, maxz_next;
    logic signed [C-1:0]   cx_reg, cy_reg, cz_reg;
    logic signed [C-1:0]   cx_next, cy_next, cz_next;
    logic signed [C:0]     sumx, sumy, sumz;
    logic                  out_vld_reg, out_vld_next;
    logic signed [C-1:0]   ocx_reg, ocy_reg, ocz_reg;
    logic signed [C-1:0]   ocx_next, ocy_next, ocz_next;
    logic [C:0]            orad_reg, orad_next;
    logic                  oovf_reg, oovf_next;
    logic                  accept;
    logic                  first;
    logic                  room;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [3*C-1:0]        rdata;
    aabbs_pkg::dist_ctrl_t dctrl;
    logic [SW-1:0]         best;
    logic                  didle;
    logic                  sq_start;
    aabbs_pkg::sqrt_stat_t sq_stat;
    logic [C:0]            root;
    logic                  out_free;

    aabbs_ram #(
        .WIDTH (3 * C),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({vert.vert_x, vert.vert_y, vert.vert_z}),
        .raddr (raddr),
        .rdata (rdata)
    );

    aabbs_dist #(
        .COORD_BITS (C)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dctrl),
        .center_x (cx_reg),
        .center_y (cy_reg),
        .center_z (cz_reg),
        .vertex   (rdata),
        .best     (best),
        .idle     (didle)
    );

    aabbs_sqrt #(
        .COORD_BITS (C)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .num   (best),
        .stat  (sq_stat),
        .root  (root)
    );

    assign vert.ready = (state_reg == aabbs_pkg::S_LOAD);
    assign accept     = vert.valid && vert.ready;
    assign first      = (count_reg == '0);
    assign room       = (count_reg < CW'(MAX_VERTICES));
    assign we         = accept && room;
    assign waddr      = count_reg[AW-1:0];
    assign raddr      = scan_reg[AW-1:0];
    assign out_free   = !out_vld_reg || sphere.ready;
    assign sumx       = {minx_reg[C-1], minx_reg} + {maxx_reg[C-1], maxx_reg};
    assign sumy       = {miny_reg[C-1], miny_reg} + {maxy_reg[C-1], maxy_reg};
    assign sumz       = {minz_reg[C-1], minz_reg} + {maxz_reg[C-1], maxz_reg};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        ovf_next     = ovf_reg;
        rd_vld_next  = 1'b0;
        minx_next    = minx_reg;
        miny_next    = miny_reg;
        minz_next    = minz_reg;
        maxx_next    = maxx_reg;
        maxy_next    = maxy_reg;
        maxz_next    = maxz_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        out_vld_next = out_vld_reg && !sphere.ready;
        ocx_next     = ocx_reg;
        ocy_next     = ocy_reg;
        ocz_next     = ocz_reg;
        orad_next    = orad_reg;
        oovf_next    = oovf_reg;
        dctrl.sample = rd_vld_reg;
        dctrl.clear  = 1'b0;
        sq_start     = 1'b0;

        unique case (state_reg)
            aabbs_pkg::S_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + 1'b1;
                        if (first || (vert.vert_x < minx_reg)) minx_next = vert.vert_x;
                        if (first || (vert.vert_y < miny_reg)) miny_next = vert.vert_y;
                        if (first || (vert.vert_z < minz_reg)) minz_next = vert.vert_z;
                        if (first || (vert.vert_x > maxx_reg)) maxx_next = vert.vert_x;
                        if (first || (vert.vert_y > maxy_reg)) maxy_next = vert.vert_y;
                        if (first || (vert.vert_z > maxz_reg)) maxz_next = vert.vert_z;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (vert.final_vertex)
                    begin
                        state_next = aabbs_pkg::S_CENTER;
                    end
                end
            end
            aabbs_pkg::S_CENTER:
            begin
                cx_next     = sumx[C:1];
                cy_next     = sumy[C:1];
                cz_next     = sumz[C:1];
                dctrl.clear = 1'b1;
                scan_next   = '0;
                state_next  = aabbs_pkg::S_SCAN;
            end
            aabbs_pkg::S_SCAN:
            begin
                if (scan_reg != count_reg)
                begin
                    scan_next   = scan_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                else if (!rd_vld_reg && didle)
                begin
                    sq_start   = 1'b1;
                    state_next = aabbs_pkg::S_ROOT;
                end
            end
            aabbs_pkg::S_ROOT:
            begin
                if (sq_stat.done)
                begin
                    state_next = aabbs_pkg::S_DONE;
                end
            end
            aabbs_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    ocx_next     = cx_reg;
                    ocy_next     = cy_reg;
                    ocz_next     = cz_reg;
                    orad_next    = root;
                    oovf_next    = ovf_reg;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = aabbs_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = aabbs_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= aabbs_pkg::S_LOAD;
            count_reg   <= '0;
            scan_reg    <= '0;
            ovf_reg     <= 1'b0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            ovf_reg     <= ovf_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minx_reg <= minx_next;
        miny_reg <= miny_next;
        minz_reg <= minz_next;
        maxx_reg <= maxx_next;
        maxy_reg <= maxy_next;
        maxz_reg <= maxz_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        ocx_reg  <= ocx_next;
        ocy_reg  <= ocy_next;
        ocz_reg  <= ocz_next;
        orad_reg <= orad_next;
        oovf_reg <= oovf_next;
    end

    assign sphere.valid    = out_vld_reg;
    assign sphere.center_x = ocx_reg;
    assign sphere.center_y = ocy_reg;
    assign sphere.center_z = ocz_reg;
    assign sphere.radius   = orad_reg;
    assign sphere.overflow = oovf_reg;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aabbs_pkg::S_SCAN) |-> (count_reg != '0))
        else $error("scan of an empty set");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == aabbs_pkg::S_SCAN))
        else $error("ram read outside the scan");

    a_root_only: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_stat.busy || sq_stat.done) |-> (state_reg == aabbs_pkg::S_ROOT))
        else $error("square root active outside the root step");

    a_load_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == aabbs_pkg::S_DONE) && out_free) |=> sphere.valid)
        else $error("result not registered");
`endif

endmodule

// ===== tb/sv/aabbs_sphere_checker.sv =====
// bounding sphere checker: predicts each sphere word from accepted vertex words and compares
module aabbs_sphere_checker #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic    clk,
    input  logic    rst_n,
    aabbs_vert_if   vert,
    aabbs_sphere_if sphere,
    output int      mismatches,
    output int      due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic [COORD_BITS:0]          radius;
        logic                         overflow;
    } sphere_word_t;

    logic signed [COORD_BITS-1:0] pts [MAX_VERTICES][3];
    logic signed [COORD_BITS-1:0] lo [3];
    logic signed [COORD_BITS-1:0] hi [3];
    logic signed [COORD_BITS-1:0] incoming [3];
    int                           stored;
    bit                           dropped;
    sphere_word_t                 spheres_due [$];

    function automatic logic [COORD_BITS:0] floor_root(input longint n);
        longint r;
        longint t;
        r = 0;
        for (int b = COORD_BITS; b >= 0; b--)
        begin
            t = r + (longint'(1) << b);
            if (t * t <= n)
                r = t;
        end
        return r[COORD_BITS:0];
    endfunction

    function automatic sphere_word_t sphere_of_set();
        longint       ctr [3];
        longint       far2;
        longint       d2;
        longint       d;
        sphere_word_t w;
        far2 = 0;
        for (int a = 0; a < 3; a++)
            ctr[a] = (longint'(lo[a]) + longint'(hi[a])) >>> 1;
        for (int i = 0; i < stored; i++)
        begin
            d2 = 0;
            for (int a = 0; a < 3; a++)
            begin
                d = ctr[a] - longint'(pts[i][a]);
                d2 += d * d;
            end
            if (d2 > far2)
                far2 = d2;
        end
        w.cx = ctr[0][COORD_BITS-1:0];
        w.cy = ctr[1][COORD_BITS-1:0];
        w.cz = ctr[2][COORD_BITS-1:0];
        w.radius = floor_root(far2);
        w.overflow = dropped;
        return w;
    endfunction

    task automatic fold_vertex(input bit tail);
        if (stored < MAX_VERTICES)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pts[stored][a] = incoming[a];
                if (stored == 0 || incoming[a] < lo[a])
                    lo[a] = incoming[a];
                if (stored == 0 || incoming[a] > hi[a])
                    hi[a] = incoming[a];
            end
            stored++;
        end
        else
            dropped = 1'b1;
        if (tail)
        begin
            spheres_due.push_back(sphere_of_set());
            stored = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic check_sphere();
        sphere_word_t got;
        sphere_word_t want;
        got.cx = sphere.center_x;
        got.cy = sphere.center_y;
        got.cz = sphere.center_z;
        got.radius = sphere.radius;
        got.overflow = sphere.overflow;
        if (spheres_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected sphere word c=(%0d,%0d,%0d) r=%0d ovf=%0b",
                         $realtime, got.cx, got.cy, got.cz, got.radius, got.overflow);
            return;
        end
        want = spheres_due.pop_front();
        if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
            got.radius !== want.radius || got.overflow !== want.overflow)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: sphere mismatch want c=(%0d,%0d,%0d) r=%0d ovf=%0b",
                         $realtime, want.cx, want.cy, want.cz, want.radius, want.overflow);
                $display("%0t: sphere mismatch got  c=(%0d,%0d,%0d) r=%0d ovf=%0b",
                         $realtime, got.cx, got.cy, got.cz, got.radius, got.overflow);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored = 0;
            dropped = 1'b0;
            spheres_due.delete();
            due = 0;
            mismatches = 0;
        end
        else
        begin
            if (vert.valid && vert.ready)
            begin
                incoming[0] = vert.vert_x;
                incoming[1] = vert.vert_y;
                incoming[2] = vert.vert_z;
                fold_vertex(vert.final_vertex);
            end
            if (sphere.valid && sphere.ready)
                check_sphere();
            due = spheres_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: vertex stimulus, sphere receiver with stalls, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS = 24;
    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   due;
    int   sent;
    bit   squeeze;
    bit   squeezed;
    int   squeeze_left;
    int   ready_run;

    aabbs_vert_if #(.COORD_BITS(COORD_BITS)) vert_ch();
    aabbs_sphere_if #(.COORD_BITS(COORD_BITS)) sphere_ch();

    aabb_bounding_sphere #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .vert(vert_ch),
        .sphere(sphere_ch)
    );

    aabbs_sphere_checker #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .vert(vert_ch),
        .sphere(sphere_ch),
        .mismatches(mismatches),
        .due(due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sphere receiver: random ready runs, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_ch.ready <= 1'b0;
            squeezed <= 1'b0;
            squeeze_left <= 0;
            ready_run <= 0;
        end
        else if (squeeze && !squeezed)
        begin
            squeezed <= 1'b1;
            squeeze_left <= 500;
            sphere_ch.ready <= 1'b0;
        end
        else if (squeeze_left > 0)
        begin
            squeeze_left <= squeeze_left - 1;
            sphere_ch.ready <= 1'b0;
        end
        else if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if ($urandom_range(0, 2) != 0)
        begin
            sphere_ch.ready <= 1'b1;
            ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                    : $urandom_range(0, 12);
        end
        else
        begin
            sphere_ch.ready <= 1'b0;
            ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
        end
    end

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_coord(input int base, input int span_log);
        case ($urandom_range(0, 15))
            0: return CMAX;
            1: return CMIN;
            default:
            begin
                if (span_log >= COORD_BITS)
                    return int'($urandom);
                return base + int'($urandom_range(0, 2 << span_log)) - (1 << span_log);
            end
        endcase
    endfunction

    task automatic push_vertex(input int x, input int y, input int z, input bit tail,
                               input int gap);
        if (gap > 0)
        begin
            vert_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vert_ch.valid <= 1'b1;
        vert_ch.vert_x <= x[COORD_BITS-1:0];
        vert_ch.vert_y <= y[COORD_BITS-1:0];
        vert_ch.vert_z <= z[COORD_BITS-1:0];
        vert_ch.final_vertex <= tail;
        @(posedge clk);
        while (!vert_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_set(input int count);
        bit steady;
        int span_log;
        int bx;
        int by;
        int bz;
        steady = ($urandom_range(0, 3) == 0);
        span_log = ($urandom_range(0, 2) == 0) ? COORD_BITS : $urandom_range(0, 20);
        bx = int'($urandom);
        by = int'($urandom);
        bz = int'($urandom);
        for (int i = 0; i < count; i++)
            push_vertex(pick_coord(bx, span_log), pick_coord(by, span_log),
                        pick_coord(bz, span_log), i == count - 1, pick_gap(steady));
    endtask

    function automatic int pick_set_size();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(1, 12);
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        squeeze <= 1'b0;
        sent = 0;
        vert_ch.valid <= 1'b0;
        vert_ch.vert_x <= '0;
        vert_ch.vert_y <= '0;
        vert_ch.vert_z <= '0;
        vert_ch.final_vertex <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertex sets, the first two at the extremes
        push_vertex(CMAX, CMAX, CMAX, 1'b1, pick_gap(1'b0));
        push_vertex(CMIN, CMIN, CMIN, 1'b1, pick_gap(1'b0));
        push_vertex(24'h555555, 24'hAAAAAA, 1, 1'b1, pick_gap(1'b0));
        // widest box, vertex 0 farthest from the center
        push_vertex(CMAX, CMIN, CMAX, 1'b0, pick_gap(1'b0));
        push_vertex(CMIN, CMAX, CMIN, 1'b0, pick_gap(1'b0));
        push_vertex(0, 0, 0, 1'b1, pick_gap(1'b0));
        // last vertex is the far one
        push_vertex(-4096, 0, 0, 1'b0, pick_gap(1'b0));
        push_vertex(256, 300, 0, 1'b0, pick_gap(1'b0));
        push_vertex(300, -300, 17, 1'b1, pick_gap(1'b0));
        // negative odd sums round down
        push_vertex(-3, -1, 5, 1'b0, pick_gap(1'b0));
        push_vertex(0, 0, 0, 1'b1, pick_gap(1'b0));
        // identical vertices, zero radius
        push_vertex(12345, -678, 9, 1'b0, pick_gap(1'b0));
        push_vertex(12345, -678, 9, 1'b1, pick_gap(1'b0));

        squeeze <= 1'b1;
        while (sent < 180)
            send_set(pick_set_size());
        // past capacity: last two vertices dropped, final one still closes the set
        send_set(MAX_VERTICES + 2);
        while (sent < 1350)
            send_set(pick_set_size());
        vert_ch.valid <= 1'b0;

        @(posedge clk);
        while (due != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
